FILE: design/psc_pkg.sv
package psc_pkg;

  // Event kinds carried by an input word.
  localparam logic [1:0] EV_FRAME = 2'd0;
  localparam logic [1:0] EV_BEGIN = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  // Result kinds.
  localparam logic [1:0] RES_REGION  = 2'd0;
  localparam logic [1:0] RES_FRAME   = 2'd1;
  localparam logic [1:0] RES_DROPPED = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_LANE   = 2'd1;
  localparam logic [1:0] ERR_STACK  = 2'd2;
  localparam logic [1:0] ERR_REGION = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCOPE_ENABLE = 2'd0;
  localparam logic [1:0] CFG_SCOPE_UNIT   = 2'd1;
  localparam logic [1:0] CFG_SCOPE_RECORD = 2'd2;

  // Widest lane number the lane table can ever need.
  localparam int LANE_FIELD_W = 6;

  // A classified word handed from the front to the back.
  typedef struct packed {
    logic [1:0]              kind;
    logic                    lane_err;
    logic [LANE_FIELD_W-1:0] lane;
    logic                    unit;
    logic [11:0]             rec;
    logic [63:0]             ts;
  } item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: design/psc_queue.sv
module psc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  psc_pkg::item_t  push_item_i,
  input  logic            pop_i,
  output psc_pkg::item_t  pop_item_o,
  output psc_pkg::qstat_t stat_o
);

  psc_pkg::item_t mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 2'd0;
      rptr_q <= 2'd0;
      cnt_q  <= 3'd0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 2'd1;
      if (pop_i) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, push_i} - {2'd0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_item_i;
  end

  assign pop_item_o   = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == 3'd4);
  assign stat_o.empty = (cnt_q == 3'd0);

endmodule

FILE: design/psc_front.sv
module psc_front #(
  parameter int MAX_LANES = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [1:0]     event_kind_i,
  input  logic [31:0]    thread_id_i,
  input  logic           source_unit_i,
  input  logic [11:0]    record_index_i,
  input  logic [63:0]    timestamp_i,
  output logic           push_o,
  output psc_pkg::item_t push_item_o
);

  localparam int LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int LCNT_W = $clog2(MAX_LANES + 1);

  logic [31:0]       ids_q [MAX_LANES];
  logic [LCNT_W-1:0] lanes_q, lanes_d;
  logic              fopen_q;
  logic              hit;
  logic [LANE_W-1:0] hit_lane, lane;
  logic              is_block, take_new, full;

  always_comb begin
    hit      = 1'b0;
    hit_lane = '0;
    for (int i = 0; i < MAX_LANES; i++) begin
      if (!hit && (LCNT_W'(i) < lanes_q) && ids_q[i] == thread_id_i) begin
        hit      = 1'b1;
        hit_lane = LANE_W'(i);
      end
    end
  end

  assign is_block = (event_kind_i == psc_pkg::EV_BEGIN) || (event_kind_i == psc_pkg::EV_END);
  assign full     = (lanes_q == LCNT_W'(MAX_LANES));
  assign take_new = accept_i && is_block && fopen_q && !hit && !full;
  assign lane     = hit ? hit_lane : lanes_q[LANE_W-1:0];
  assign lanes_d  = lanes_q + LCNT_W'(1);

  assign push_o = accept_i && ((event_kind_i == psc_pkg::EV_FRAME) || (is_block && fopen_q));

  always_comb begin
    push_item_o.kind     = event_kind_i;
    push_item_o.lane_err = is_block && !hit && full;
    push_item_o.lane     = (push_item_o.lane_err) ? '0 : psc_pkg::LANE_FIELD_W'(lane);
    push_item_o.unit     = source_unit_i;
    push_item_o.rec      = record_index_i;
    push_item_o.ts       = timestamp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q <= '0;
      fopen_q <= 1'b0;
    end else begin
      if (accept_i && event_kind_i == psc_pkg::EV_FRAME) fopen_q <= 1'b1;
      if (take_new) lanes_q <= lanes_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_new) ids_q[lanes_q[LANE_W-1:0]] <= thread_id_i;
  end

endmodule

FILE: design/psc_back.sv
module psc_back #(
  parameter int MAX_LANES         = 8,
  parameter int STACK_DEPTH       = 16,
  parameter int REGIONS_PER_FRAME = 256,
  parameter int FRAME_BITS        = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  psc_pkg::qstat_t stat_i,
  input  psc_pkg::item_t  item_i,
  output logic            pop_o,
  input  logic            scope_enable_i,
  input  logic            scope_unit_i,
  input  logic [11:0]     scope_record_i,
  output logic            result_valid_o,
  output logic [1:0]      result_kind_o,
  output logic [1:0]      error_code_o,
  output logic [7:0]      frame_number_o,
  output logic            span_unit_o,
  output logic [11:0]     span_record_o,
  output logic [2:0]      lane_o,
  output logic [63:0]     start_offset_o,
  output logic [63:0]     end_offset_o,
  output logic [63:0]     cycle_count_o
);

  localparam int LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W  = $clog2(STACK_DEPTH);
  localparam int AW     = $clog2(MAX_LANES * STACK_DEPTH);
  localparam int RCNT_W = $clog2(REGIONS_PER_FRAME + 1);
  localparam int TAG_W  = 13 + FRAME_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EVAL} state_e;

  state_e state_q;
  logic [63:0]           start_mem [MAX_LANES * STACK_DEPTH];
  logic [TAG_W-1:0]      tag_mem   [MAX_LANES * STACK_DEPTH];
  logic [LVL_W-1:0]      levels_q  [MAX_LANES];
  logic                  fopen_q;
  logic [63:0]           fstart_q;
  logic [FRAME_BITS-1:0] fcnt_q;
  logic [RCNT_W-1:0]     regions_q;
  psc_pkg::item_t        it_q;
  logic [63:0]           rd_start_q, so_q, eo_q;
  logic [TAG_W-1:0]      rd_top_q, rd_par_q;
  logic [LVL_W-1:0]      level_q;

  logic [LANE_W-1:0] in_lane, it_lane;
  logic [LVL_W-1:0]  in_level;
  logic [AW-1:0]     wr_addr, top_addr, par_addr;
  logic              do_push;
  logic [TAG_W-1:0]  cur_tag;
  logic              parent_ok;

  assign in_lane  = item_i.lane[LANE_W-1:0];
  assign it_lane  = it_q.lane[LANE_W-1:0];
  assign in_level = levels_q[in_lane];
  assign wr_addr  = AW'(AW'(in_lane) * AW'(STACK_DEPTH) + AW'(in_level[IDX_W-1:0]));
  assign top_addr = AW'(AW'(in_lane) * AW'(STACK_DEPTH) + AW'(IDX_W'(in_level - LVL_W'(1))));
  assign par_addr = AW'(AW'(in_lane) * AW'(STACK_DEPTH) + AW'(IDX_W'(in_level - LVL_W'(2))));
  assign pop_o    = (state_q == ST_IDLE) && !stat_i.empty;
  assign do_push  = pop_o && item_i.kind == psc_pkg::EV_BEGIN && !item_i.lane_err
                    && in_level < LVL_W'(STACK_DEPTH);
  assign cur_tag  = {item_i.unit, item_i.rec, fcnt_q};

  // The parent is the entry below the top; a top-level block has none.
  always_comb begin
    if (level_q == LVL_W'(1)) begin
      parent_ok = !scope_enable_i;
    end else begin
      parent_ok = scope_enable_i && rd_par_q[TAG_W-1] == scope_unit_i
                  && rd_par_q[TAG_W-2 -: 12] == scope_record_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      start_mem[wr_addr] <= item_i.ts;
      tag_mem[wr_addr]   <= cur_tag;
    end
    rd_start_q <= start_mem[top_addr];
    rd_top_q   <= tag_mem[top_addr];
    rd_par_q   <= tag_mem[par_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      fopen_q        <= 1'b0;
      fstart_q       <= '0;
      fcnt_q         <= '0;
      regions_q      <= '0;
      result_valid_o <= 1'b0;
      for (int i = 0; i < MAX_LANES; i++) levels_q[i] <= '0;
    end else begin
      result_valid_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            it_q    <= item_i;
            level_q <= in_level;
            span_unit_o    <= item_i.unit;
            span_record_o  <= item_i.rec;
            lane_o         <= 3'(in_lane);
            frame_number_o <= 8'(fcnt_q);
            error_code_o   <= psc_pkg::ERR_NONE;
            start_offset_o <= '0;
            end_offset_o   <= '0;
            cycle_count_o  <= '0;
            if (item_i.kind == psc_pkg::EV_FRAME) begin
              if (fopen_q) begin
                result_valid_o <= 1'b1;
                result_kind_o  <= psc_pkg::RES_FRAME;
                span_unit_o    <= 1'b0;
                span_record_o  <= '0;
                lane_o         <= '0;
                end_offset_o   <= item_i.ts - fstart_q;
                cycle_count_o  <= item_i.ts - fstart_q;
                fcnt_q         <= fcnt_q + FRAME_BITS'(1);
              end
              fopen_q   <= 1'b1;
              fstart_q  <= item_i.ts;
              regions_q <= '0;
            end else if (item_i.lane_err) begin
              result_valid_o <= 1'b1;
              result_kind_o  <= psc_pkg::RES_DROPPED;
              error_code_o   <= psc_pkg::ERR_LANE;
              lane_o         <= '0;
            end else if (item_i.kind == psc_pkg::EV_BEGIN) begin
              if (do_push) begin
                levels_q[in_lane] <= in_level + LVL_W'(1);
              end else begin
                result_valid_o <= 1'b1;
                result_kind_o  <= psc_pkg::RES_DROPPED;
                error_code_o   <= psc_pkg::ERR_STACK;
              end
            end else if (in_level != '0) begin
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_IDLE;
          if (rd_top_q[TAG_W-1 -: 13] == {it_q.unit, it_q.rec}) begin
            levels_q[it_lane] <= level_q - LVL_W'(1);
            if (rd_top_q[FRAME_BITS-1:0] == fcnt_q && parent_ok) begin
              so_q    <= rd_start_q - fstart_q;
              eo_q    <= it_q.ts - fstart_q;
              state_q <= ST_EVAL;
            end
          end
        end
        ST_EVAL: begin
          state_q <= ST_IDLE;
          if (eo_q > so_q) begin
            result_valid_o <= 1'b1;
            start_offset_o <= so_q;
            end_offset_o   <= eo_q;
            cycle_count_o  <= eo_q - so_q;
            if (regions_q >= RCNT_W'(REGIONS_PER_FRAME)) begin
              result_kind_o <= psc_pkg::RES_DROPPED;
              error_code_o  <= psc_pkg::ERR_REGION;
            end else begin
              result_kind_o <= psc_pkg::RES_REGION;
              regions_q     <= regions_q + RCNT_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/profile_span_collator_core.sv
// A frame marker or a lane or stack drop is strobed when the back pops it; a block
// end that yields a region is strobed after its pop, read and eval states. Begins and
// markers take only the back's idle state; block ends may add read and eval, set by the
// registered stack memory read followed by the offset compare; busy rises only when
// the four-word queue is full. Reset (rst_ni low, asynchronous) clears frame state,
// lanes, stack levels and queue. The receiver cannot stall: each result is strobed once.
module profile_span_collator_core #(
  parameter int MAX_LANES         = 8,
  parameter int STACK_DEPTH       = 16,
  parameter int REGIONS_PER_FRAME = 256,
  parameter int FRAME_BITS        = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  event_kind_i,
  input  logic [31:0] thread_id_i,
  input  logic        source_unit_i,
  input  logic [11:0] record_index_i,
  input  logic [63:0] timestamp_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [1:0]  result_kind_o,
  output logic [1:0]  error_code_o,
  output logic [7:0]  frame_number_o,
  output logic        span_unit_o,
  output logic [11:0] span_record_o,
  output logic [2:0]  lane_o,
  output logic [63:0] start_offset_o,
  output logic [63:0] end_offset_o,
  output logic [63:0] cycle_count_o
);

  // The front classifies each word and assigns its lane as it is accepted; the back
  // owns frame state and the per-lane stacks. The queue lets the front keep
  // taking words while the back works through a block end.
  psc_pkg::item_t  push_item, pop_item;
  psc_pkg::qstat_t qstat;
  logic            push, pop, accept;
  logic            scope_enable_q, scope_unit_q;
  logic [11:0]     scope_record_q;

  assign busy        = qstat.full;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Configuration words are taken at once; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scope_enable_q <= 1'b0;
      scope_unit_q   <= 1'b0;
      scope_record_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        psc_pkg::CFG_SCOPE_ENABLE: scope_enable_q <= cfg_data_i[0];
        psc_pkg::CFG_SCOPE_UNIT:   scope_unit_q   <= cfg_data_i[0];
        psc_pkg::CFG_SCOPE_RECORD: scope_record_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  psc_front #(.MAX_LANES(MAX_LANES)) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .event_kind_i, .thread_id_i,
    .source_unit_i, .record_index_i, .timestamp_i,
    .push_o(push), .push_item_o(push_item)
  );

  psc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_item_i(push_item),
    .pop_i(pop), .pop_item_o(pop_item), .stat_o(qstat)
  );

  psc_back #(
    .MAX_LANES(MAX_LANES), .STACK_DEPTH(STACK_DEPTH),
    .REGIONS_PER_FRAME(REGIONS_PER_FRAME), .FRAME_BITS(FRAME_BITS)
  ) u_back (
    .clk_i, .rst_ni, .stat_i(qstat), .item_i(pop_item), .pop_o(pop),
    .scope_enable_i(scope_enable_q), .scope_unit_i(scope_unit_q),
    .scope_record_i(scope_record_q),
    .result_valid_o, .result_kind_o, .error_code_o, .frame_number_o,
    .span_unit_o, .span_record_o, .lane_o, .start_offset_o, .end_offset_o,
    .cycle_count_o
  );

endmodule

FILE: design/psc_checker.sv
module psc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        result_valid_o,
  input logic [1:0]  result_kind_o,
  input logic [1:0]  error_code_o,
  input logic [63:0] start_offset_o,
  input logic [63:0] end_offset_o,
  input logic [63:0] cycle_count_o
);

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_kind_o <= psc_pkg::RES_DROPPED) else $error("bad result kind");

  a_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o == psc_pkg::RES_REGION |->
      error_code_o == psc_pkg::ERR_NONE && end_offset_o > start_offset_o
      && cycle_count_o == end_offset_o - start_offset_o)
    else $error("region word inconsistent");

  a_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o == psc_pkg::RES_FRAME |->
      start_offset_o == 64'd0 && cycle_count_o == end_offset_o)
    else $error("frame word inconsistent");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o == psc_pkg::RES_DROPPED |->
      error_code_o != psc_pkg::ERR_NONE)
    else $error("dropped word without error");

endmodule

bind profile_span_collator_core psc_checker u_psc_checker (
  .clk_i, .rst_ni, .result_valid_o, .result_kind_o, .error_code_o,
  .start_offset_o, .end_offset_o, .cycle_count_o
);

FILE: bench/psc_span_checker.sv
`timescale 1ns / 100ps

// Watches the event, configuration and result channels, predicts the result word,
// if any, of every accepted event and compares it with what the block reports.
module psc_span_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  event_kind_i,
  input  logic [31:0] thread_id_i,
  input  logic        source_unit_i,
  input  logic [11:0] record_index_i,
  input  logic [63:0] timestamp_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        result_valid_i,
  input  logic [1:0]  result_kind_i,
  input  logic [1:0]  error_code_i,
  input  logic [7:0]  frame_number_i,
  input  logic        span_unit_i,
  input  logic [11:0] span_record_i,
  input  logic [2:0]  lane_i,
  input  logic [63:0] start_offset_i,
  input  logic [63:0] end_offset_i,
  input  logic [63:0] cycle_count_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int NUM_LANES = 8;
  localparam int DEPTH     = 16;
  localparam int REGIONS   = 256;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  err;
    logic [7:0]  frame;
    logic        unit;
    logic [11:0] rec;
    logic [2:0]  lane;
    logic [63:0] so;
    logic [63:0] eo;
    logic [63:0] cyc;
  } span_word_t;

  span_word_t  span_q[$];

  logic        scope_en;
  logic        scope_unit;
  logic [11:0] scope_rec;

  logic        frame_open;
  logic [63:0] frame_t0;
  logic [7:0]  frame_cnt;
  int          regions_used;
  int          lanes_used;
  logic [31:0] lane_tid   [NUM_LANES];
  int          level      [NUM_LANES];
  logic [63:0] open_ts    [NUM_LANES*DEPTH];
  logic        open_unit  [NUM_LANES*DEPTH];
  logic [11:0] open_rec   [NUM_LANES*DEPTH];
  logic [7:0]  open_frame [NUM_LANES*DEPTH];

  function automatic span_word_t make_word(logic [1:0] kind, logic [1:0] err, logic unit,
                                           logic [11:0] rec, int ln, logic [63:0] so,
                                           logic [63:0] eo, logic [63:0] cyc);
    span_word_t w;
    w.kind = kind; w.err = err; w.frame = frame_cnt; w.unit = unit; w.rec = rec;
    w.lane = ln[2:0]; w.so = so; w.eo = eo; w.cyc = cyc;
    return w;
  endfunction

  // Updates the collation state for one event and queues its result, if any.
  function automatic void collate(logic [1:0] kind, logic [31:0] tid, logic unit,
                                  logic [11:0] rec, logic [63:0] ts);
    int          ln;
    int          top;
    bit          found;
    bit          parent_ok;
    logic [63:0] so;
    logic [63:0] eo;
    ln = 0;
    found = 0;
    if (kind == psc_pkg::EV_FRAME) begin
      if (frame_open) begin
        span_q.push_back(make_word(psc_pkg::RES_FRAME, psc_pkg::ERR_NONE, 1'b0, 12'd0, 0,
                                   64'd0, ts - frame_t0, ts - frame_t0));
        frame_cnt = frame_cnt + 8'd1;
      end
      frame_open = 1'b1;
      frame_t0 = ts;
      regions_used = 0;
      return;
    end
    if (kind != psc_pkg::EV_BEGIN && kind != psc_pkg::EV_END) return;
    if (!frame_open) return;
    for (int i = 0; i < lanes_used; i++) begin
      if (!found && lane_tid[i] == tid) begin
        ln = i;
        found = 1;
      end
    end
    if (!found) begin
      if (lanes_used >= NUM_LANES) begin
        span_q.push_back(make_word(psc_pkg::RES_DROPPED, psc_pkg::ERR_LANE, unit, rec,
                                   0, 0, 0, 0));
        return;
      end
      ln = lanes_used;
      lane_tid[ln] = tid;
      lanes_used++;
    end
    if (kind == psc_pkg::EV_BEGIN) begin
      if (level[ln] >= DEPTH) begin
        span_q.push_back(make_word(psc_pkg::RES_DROPPED, psc_pkg::ERR_STACK, unit, rec,
                                   ln, 0, 0, 0));
        return;
      end
      top = ln * DEPTH + level[ln];
      open_ts[top] = ts;
      open_unit[top] = unit;
      open_rec[top] = rec;
      open_frame[top] = frame_cnt;
      level[ln]++;
      return;
    end
    if (level[ln] == 0) return;
    top = ln * DEPTH + level[ln] - 1;
    if (open_unit[top] != unit || open_rec[top] != rec) return;
    level[ln]--;
    // A block that began in an earlier frame is dropped silently.
    if (open_frame[top] != frame_cnt) return;
    if (level[ln] == 0) parent_ok = !scope_en;
    else parent_ok = scope_en && open_unit[top-1] == scope_unit &&
                     open_rec[top-1] == scope_rec;
    if (!parent_ok) return;
    so = open_ts[top] - frame_t0;
    eo = ts - frame_t0;
    if (!(eo > so)) return;
    if (regions_used >= REGIONS) begin
      span_q.push_back(make_word(psc_pkg::RES_DROPPED, psc_pkg::ERR_REGION, unit, rec, ln,
                                 so, eo, eo - so));
      return;
    end
    regions_used++;
    span_q.push_back(make_word(psc_pkg::RES_REGION, psc_pkg::ERR_NONE, unit, rec, ln,
                               so, eo, eo - so));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    span_word_t got;
    span_word_t want;
    if (!rst_ni) begin
      scope_en = 0; scope_unit = 0; scope_rec = 0;
      frame_open = 0; frame_t0 = 0; frame_cnt = 0;
      regions_used = 0; lanes_used = 0;
      for (int i = 0; i < NUM_LANES; i++) level[i] = 0;
      span_q.delete();
    end else begin
      // Results are compared before the event of this edge is predicted, since
      // a word leaving now always belongs to an earlier event.
      if (result_valid_i) begin
        got = '{result_kind_i, error_code_i, frame_number_i, span_unit_i, span_record_i,
                lane_i, start_offset_i, end_offset_i, cycle_count_i};
        if (span_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count_o++;
        end else begin
          want = span_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch expected %h actual %h", $time, want, got);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          psc_pkg::CFG_SCOPE_ENABLE: scope_en = cfg_data_i[0];
          psc_pkg::CFG_SCOPE_UNIT:   scope_unit = cfg_data_i[0];
          psc_pkg::CFG_SCOPE_RECORD: scope_rec = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        collate(event_kind_i, thread_id_i, source_unit_i, record_index_i, timestamp_i);
    end
    pending_o = span_q.size();
  end

  initial fail_count_o = 0;

endmodule

FILE: bench/profile_span_collator_core_test.sv
`timescale 1ns / 100ps

// Top of the collator bench. It drives trace events and register writes; the
// checker beside the block predicts and compares every result word.
module profile_span_collator_core_test;

  localparam int LIMIT = 400000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  event_kind_i = '0;
  logic [31:0] thread_id_i = '0;
  logic        source_unit_i = 0;
  logic [11:0] record_index_i = '0;
  logic [63:0] timestamp_i = '0;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [1:0]  result_kind_o;
  logic [1:0]  error_code_o;
  logic [7:0]  frame_number_o;
  logic        span_unit_o;
  logic [11:0] span_record_o;
  logic [2:0]  lane_o;
  logic [63:0] start_offset_o;
  logic [63:0] end_offset_o;
  logic [63:0] cycle_count_o;
  int          fail_count;
  int          pending;
  int          cycles = 0;

  // Stimulus bookkeeping: a pool of thread ids, a shadow stack of block tags per
  // pool slot so that most block ends match, and a running trace clock.
  logic [31:0] thread_pool [10];
  logic [12:0] shadow_tag  [10][20];
  int          shadow_depth[10];
  logic [63:0] trace_clock = 0;
  logic [11:0] scope_tag_rec = 0;
  logic        scope_tag_unit = 0;
  bit          no_idle = 0;

  profile_span_collator_core u_top (.*);

  psc_span_checker u_check (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .event_kind_i, .thread_id_i,
    .source_unit_i, .record_index_i, .timestamp_i, .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .result_valid_i(result_valid_o), .result_kind_i(result_kind_o),
    .error_code_i(error_code_o), .frame_number_i(frame_number_o),
    .span_unit_i(span_unit_o), .span_record_i(span_record_o), .lane_i(lane_o),
    .start_offset_i(start_offset_o), .end_offset_i(end_offset_o),
    .cycle_count_i(cycle_count_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Presents one event word and holds it until the block takes it. Before the
  // word the sender idles now and then, except inside the quiet stretch.
  task automatic send_word(logic [1:0] kind, logic [31:0] tid, logic unit,
                           logic [11:0] rec, logic [63:0] ts);
    if (!no_idle && $urandom_range(0, 99) < 23) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    event_kind_i <= kind;
    thread_id_i <= tid;
    source_unit_i <= unit;
    record_index_i <= rec;
    timestamp_i <= ts;
    start <= 1;
    do @(posedge clk_i); while (busy);
  endtask

  // Leaves valid high; the caller drops it after the last write of a burst.
  task automatic write_reg(logic [1:0] idx, logic [11:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Waits for every expected word, then lets the pipeline run dry before a write.
  task automatic drain();
    start <= 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic set_scope(logic en, logic unit, logic [11:0] rec);
    drain();
    write_reg(psc_pkg::CFG_SCOPE_ENABLE, {11'd0, en});
    write_reg(psc_pkg::CFG_SCOPE_UNIT, {11'd0, unit});
    write_reg(psc_pkg::CFG_SCOPE_RECORD, rec);
    cfg_valid_i <= 0;
    scope_tag_unit = unit;
    scope_tag_rec = rec;
  endtask

  // One random event. Most are well-formed begin and end pairs on pooled
  // threads; the rest are frame markers, unknown kinds and garbage words.
  task automatic random_word();
    int          r;
    int          slot;
    logic [12:0] tag;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) trace_clock = {$urandom, $urandom};
    else trace_clock = trace_clock + $urandom_range(0, 40);
    if (r < 6) begin
      send_word(psc_pkg::EV_FRAME, $urandom, 1'($urandom), 12'($urandom), trace_clock);
    end else if (r < 8) begin
      send_word(2'd3, $urandom, 1'($urandom), 12'($urandom), trace_clock);
    end else if (r < 11) begin
      send_word(2'($urandom_range(1, 2)), $urandom, 1'($urandom), 12'($urandom),
                trace_clock);
    end else begin
      slot = ($urandom_range(0, 99) < 3) ? $urandom_range(8, 9) : $urandom_range(0, 6);
      if (shadow_depth[slot] > 0 && $urandom_range(0, 1)) begin
        shadow_depth[slot]--;
        tag = shadow_tag[slot][shadow_depth[slot]];
        // A few ends carry a wrong tag and must be ignored.
        if ($urandom_range(0, 19) == 0) tag = tag ^ 13'd1;
        send_word(psc_pkg::EV_END, thread_pool[slot], tag[12], tag[11:0], trace_clock);
      end else begin
        case ($urandom_range(0, 3))
          0: tag = {scope_tag_unit, scope_tag_rec};
          1: tag = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 12'hfff};
          2: tag = 13'd0;
          default: tag = 13'($urandom);
        endcase
        // The shadow runs slightly deeper than the block so overflow is hit.
        if (shadow_depth[slot] < 18) begin
          shadow_tag[slot][shadow_depth[slot]] = tag;
          shadow_depth[slot]++;
        end
        send_word(psc_pkg::EV_BEGIN, thread_pool[slot], tag[12], tag[11:0], trace_clock);
      end
    end
  endtask

  initial begin
    thread_pool[0] = 32'h0;
    thread_pool[1] = 32'hffff_ffff;
    for (int i = 2; i < 10; i++) thread_pool[i] = $urandom;
    for (int i = 0; i < 10; i++) shadow_depth[i] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    set_scope(1'b0, 1'b0, 12'd0);

    // Directed part. A block event before the first frame marker is ignored,
    // and the first marker opens frame 0 without a result.
    send_word(psc_pkg::EV_BEGIN, thread_pool[0], 1'b1, 12'hfff, 64'd5);
    send_word(psc_pkg::EV_FRAME, 32'd0, 1'b0, 12'd0, 64'd0);
    send_word(2'd3, thread_pool[0], 1'b1, 12'hfff, 64'd10);
    send_word(psc_pkg::EV_END, thread_pool[0], 1'b1, 12'hfff, 64'd20);
    send_word(psc_pkg::EV_BEGIN, thread_pool[0], 1'b1, 12'hfff, 64'd100);
    send_word(psc_pkg::EV_END, thread_pool[0], 1'b0, 12'hfff, 64'd150);
    send_word(psc_pkg::EV_END, thread_pool[0], 1'b1, 12'hfff, 64'd200);
    send_word(psc_pkg::EV_BEGIN, thread_pool[1], 1'b0, 12'd0, 64'd300);
    send_word(psc_pkg::EV_END, thread_pool[1], 1'b0, 12'd0, 64'd300);
    send_word(psc_pkg::EV_BEGIN, thread_pool[1], 1'b0, 12'd7, 64'd400);
    send_word(psc_pkg::EV_FRAME, 32'd0, 1'b0, 12'd0, 64'hffff_ffff_ffff_fff0);
    // The block above spans frames and is popped silently.
    send_word(psc_pkg::EV_END, thread_pool[1], 1'b0, 12'd7, 64'hffff_ffff_ffff_fff8);
    send_word(psc_pkg::EV_BEGIN, thread_pool[0], 1'b0, 12'd1, 64'hffff_ffff_ffff_ffff);
    send_word(psc_pkg::EV_END, thread_pool[0], 1'b0, 12'd1, 64'd20);
    send_word(psc_pkg::EV_BEGIN, thread_pool[0], 1'b1, 12'd2, 64'd30);
    send_word(psc_pkg::EV_END, thread_pool[0], 1'b1, 12'd2, 64'd25);
    send_word(psc_pkg::EV_FRAME, 32'd0, 1'b0, 12'd0, 64'd0);
    trace_clock = 0;

    // A frame with more regions than the table holds, on a lane of its own.
    for (int i = 0; i < 262; i++) begin
      trace_clock = trace_clock + 2;
      send_word(psc_pkg::EV_BEGIN, thread_pool[7], i[0], i[11:0], trace_clock);
      trace_clock = trace_clock + 3;
      send_word(psc_pkg::EV_END, thread_pool[7], i[0], i[11:0], trace_clock);
    end

    // Random part over several scope settings, the extremes among them.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: set_scope(1'b1, 1'b1, 12'hfff);
        2: set_scope(1'b1, 1'b0, 12'd0);
        3: set_scope(1'b1, 1'($urandom), 12'($urandom));
        default: ;
      endcase
      for (int i = 0; i < 230; i++) begin
        no_idle = (phase == 1 && i >= 60 && i < 160);
        random_word();
      end
    end
    no_idle = 0;

    start <= 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
